// File: rtl/sfd_pkg.sv
package sfd_pkg;

  localparam int MAX_FRAME_BYTES = 255;

  // frame_format codes
  localparam logic [1:0] FMT_TYPED = 2'd0;
  localparam logic [1:0] FMT_LEN   = 2'd1;
  localparam logic [1:0] FMT_FIXED = 2'd2;

  // configuration register indexes
  localparam logic CFG_FRAME_FORMAT = 1'b0;
  localparam logic CFG_FIXED_LENGTH = 1'b1;

  localparam logic [7:0] FIXED_LENGTH_RESET = 8'd61;
  localparam logic [7:0] FIXED_LENGTH_MIN   = 8'd6;

  localparam logic [7:0] SYNC_A_FIRST  = 8'hA5;
  localparam logic [7:0] SYNC_A_SECOND = 8'h5A;
  localparam logic [7:0] SYNC_B_FIRST  = 8'h55;
  localparam logic [7:0] SYNC_B_SECOND = 8'hAA;
  localparam logic [7:0] TAIL_BYTE     = 8'hBB;

  localparam logic [7:0] LEN_14 = 8'h14;
  localparam logic [7:0] LEN_16 = 8'h16;
  localparam logic [7:0] LEN_13 = 8'h13;
  localparam logic [7:0] TYPE_A1 = 8'hA1;
  localparam logic [7:0] TYPE_A2 = 8'hA2;
  localparam logic [7:0] TYPE_A3 = 8'hA3;
  localparam logic [7:0] TYPE_A6 = 8'hA6;

  typedef enum logic [1:0] {
    PH_HUNT  = 2'd0,
    PH_SYNC1 = 2'd1,
    PH_FRAME = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    KIND_BYTE    = 2'd0,
    KIND_GOOD    = 2'd1,
    KIND_BAD_SUM = 2'd2,
    KIND_REJECT  = 2'd3
  } kind_t;

  typedef struct packed {
    phase_t     hunt_phase;
    logic [7:0] position_count;
    logic [7:0] running_sum;
    logic [7:0] announced_length;
    logic [7:0] held_type;
  } deframe_state_t;

  typedef struct packed {
    logic       valid;
    kind_t      item_kind;
    logic [7:0] frame_byte;
    logic [7:0] byte_index;
    logic [7:0] frame_type;
    logic       last_of_frame;
  } result_t;

  function automatic logic pair_ok(input logic [7:0] len, input logic [7:0] typ);
    logic match;
    match = (len == LEN_14 && typ == TYPE_A1) || (len == LEN_16 && typ == TYPE_A2) ||
            (len == LEN_14 && typ == TYPE_A3) || (len == LEN_13 && typ == TYPE_A6);
    return match && ({1'b0, len} <= 9'(MAX_FRAME_BYTES - 1));
  endfunction

endpackage

// File: rtl/sfd_step.sv
module sfd_step import sfd_pkg::*; (
  input  deframe_state_t st,
  input  logic [7:0]     rx_byte,
  input  logic [1:0]     frame_format,
  input  logic [7:0]     fixed_frame_length,
  output deframe_state_t st_nxt,
  output result_t        res
);

  logic [1:0] fmt;
  logic [7:0] sync_first;
  logic [7:0] sync_second;
  logic [7:0] flen;
  logic [7:0] flen_m1;
  logic [7:0] flen_m2;
  logic       advance;
  logic       finish;
  kind_t      end_kind;

  // reserved format code behaves as the typed format
  assign fmt = (frame_format == FMT_LEN)   ? FMT_LEN :
               (frame_format == FMT_FIXED) ? FMT_FIXED : FMT_TYPED;

  assign sync_first  = (fmt == FMT_FIXED) ? SYNC_B_FIRST  : SYNC_A_FIRST;
  assign sync_second = (fmt == FMT_FIXED) ? SYNC_B_SECOND : SYNC_A_SECOND;

  always_comb begin
    if (fixed_frame_length < FIXED_LENGTH_MIN) begin
      flen = FIXED_LENGTH_MIN;
    end else if ({1'b0, fixed_frame_length} > 9'(MAX_FRAME_BYTES)) begin
      flen = 8'(MAX_FRAME_BYTES);
    end else begin
      flen = fixed_frame_length;
    end
  end

  assign flen_m1 = flen - 8'd1;
  assign flen_m2 = flen - 8'd2;

  always_comb begin
    st_nxt            = st;
    advance           = 1'b0;
    finish            = 1'b0;
    end_kind          = KIND_BYTE;
    res.valid         = 1'b0;
    res.item_kind     = KIND_BYTE;
    res.frame_byte    = rx_byte;
    res.byte_index    = st.position_count;
    res.last_of_frame = 1'b0;

    case (st.hunt_phase)
      PH_SYNC1: begin
        if (rx_byte == sync_second) begin
          st_nxt.hunt_phase       = PH_FRAME;
          st_nxt.position_count   = 8'd2;
          st_nxt.running_sum      = (fmt == FMT_TYPED) ? 8'hFF : 8'h00;
          st_nxt.announced_length = 8'd0;
          st_nxt.held_type        = 8'd0;
          res.valid               = 1'b1;
          res.byte_index          = 8'd1;
        end else begin
          st_nxt.hunt_phase = (rx_byte == sync_first) ? PH_SYNC1 : PH_HUNT;
        end
      end
      PH_FRAME: begin
        case (fmt)
          FMT_LEN: begin
            if (st.position_count <= 8'd2) begin
              st_nxt.announced_length = rx_byte;
              if (rx_byte < 8'd2) begin
                finish   = 1'b1;
                end_kind = KIND_BAD_SUM;
              end else if ({1'b0, rx_byte} > 9'(MAX_FRAME_BYTES - 2)) begin
                finish   = 1'b1;
                end_kind = KIND_REJECT;
              end else begin
                advance = 1'b1;
              end
            end else if ({1'b0, st.position_count} >= {1'b0, st.announced_length} + 9'd1) begin
              finish   = 1'b1;
              end_kind = (st.running_sum == rx_byte) ? KIND_GOOD : KIND_BAD_SUM;
            end else begin
              advance = 1'b1;
            end
            if (advance) begin
              st_nxt.running_sum = st.running_sum + rx_byte;
            end
          end
          FMT_FIXED: begin
            if (st.position_count >= flen_m1) begin
              finish   = 1'b1;
              end_kind = (rx_byte != TAIL_BYTE) ? KIND_REJECT :
                         (st.running_sum == 8'd0) ? KIND_GOOD : KIND_BAD_SUM;
            end else begin
              advance = 1'b1;
              // checksum byte cancels the sum when it matches
              if (st.position_count == flen_m2) begin
                st_nxt.running_sum = st.running_sum - rx_byte;
              end else begin
                st_nxt.running_sum = st.running_sum + rx_byte;
              end
            end
          end
          default: begin
            if (st.position_count <= 8'd2) begin
              st_nxt.announced_length = rx_byte;
              advance = 1'b1;
            end else if (st.position_count == 8'd3) begin
              st_nxt.held_type = rx_byte;
              if (!pair_ok(st.announced_length, rx_byte)) begin
                finish   = 1'b1;
                end_kind = KIND_REJECT;
              end else begin
                advance = 1'b1;
              end
            end else if (st.position_count >= st.announced_length) begin
              finish   = 1'b1;
              // a sum of FF can never match
              end_kind = (st.running_sum != 8'hFF && st.running_sum + 8'd1 == rx_byte) ?
                         KIND_GOOD : KIND_BAD_SUM;
            end else begin
              advance = 1'b1;
            end
            if (advance) begin
              st_nxt.running_sum = st.running_sum + rx_byte;
            end
          end
        endcase

        if (finish) begin
          st_nxt.hunt_phase     = PH_HUNT;
          st_nxt.position_count = 8'd0;
          res.valid             = 1'b1;
          res.item_kind         = end_kind;
          res.last_of_frame     = 1'b1;
        end else begin
          st_nxt.position_count = st.position_count + 8'd1;
          res.valid             = 1'b1;
        end
      end
      default: begin
        st_nxt.hunt_phase = (rx_byte == sync_first) ? PH_SYNC1 : PH_HUNT;
      end
    endcase

    res.frame_type = st_nxt.held_type;
  end

endmodule

// File: rtl/sensor_frame_deframer.sv
// Output: a two-entry stage (output register plus skid register) registers each result.
// Throughput: one byte per cycle while the skid register is empty; in_tready is low while
// it holds an entry. The frame state updates in the accept cycle.
// Reset: synchronous on rst_n low; hunts for sync, format 0, fixed length 61,
// output stage empty.
module sensor_frame_deframer import sfd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte

  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [7:0] frame_byte, [15:8] byte_index, [23:16] frame_type
  output logic [1:0]  out_tuser,  // [1:0] item_kind
  output logic        out_tlast,

  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_wdata
);

  deframe_state_t st_r;
  deframe_state_t st_nxt;
  result_t        res;
  logic [1:0]     frame_format_r;
  logic [7:0]     fixed_frame_length_r;

  result_t out_r;
  result_t skid_r;
  logic    out_valid_r;
  logic    skid_valid_r;
  logic    in_accept;
  logic    push;
  logic    pop;

  sfd_step u_step (
    .st                 (st_r),
    .rx_byte            (in_tdata),
    .frame_format       (frame_format_r),
    .fixed_frame_length (fixed_frame_length_r),
    .st_nxt             (st_nxt),
    .res                (res)
  );

  assign in_tready = !skid_valid_r;
  assign in_accept = in_tvalid && in_tready;
  assign push      = in_accept && res.valid;
  assign pop       = out_valid_r && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r                 <= '0;
      frame_format_r       <= FMT_TYPED;
      fixed_frame_length_r <= FIXED_LENGTH_RESET;
    end else if (cfg_we) begin
      // any register write drops the current frame
      st_r.hunt_phase     <= PH_HUNT;
      st_r.position_count <= 8'd0;
      if (cfg_index == CFG_FRAME_FORMAT) begin
        frame_format_r <= cfg_wdata[1:0];
      end else begin
        fixed_frame_length_r <= cfg_wdata;
      end
    end else if (in_accept) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (out_valid_r && !pop) begin
        skid_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (pop) begin
        out_r <= skid_r;
      end
    end else if (push) begin
      if (out_valid_r && !pop) begin
        skid_r <= res;
      end else begin
        out_r <= res;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_r.frame_type, out_r.byte_index, out_r.frame_byte};
  assign out_tuser  = out_r.item_kind;
  assign out_tlast  = out_r.last_of_frame;

`ifndef ASSERT_OFF
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held while output register empty");

  a_cfg_rehunt: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> (st_r.hunt_phase == PH_HUNT && st_r.position_count == 8'd0))
    else $error("config write did not return to hunting");

  a_last_is_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.last_of_frame == (out_r.item_kind != KIND_BYTE)))
    else $error("last flag and item kind disagree");

  a_pos_outside_frame: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.hunt_phase != PH_FRAME |-> st_r.position_count == 8'd0)
    else $error("position count nonzero outside a frame");

  a_pos_inside_frame: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.hunt_phase == PH_FRAME |-> st_r.position_count >= 8'd2)
    else $error("position count below two inside a frame");
`endif

endmodule
